[rtl/jtlr_pkg.sv]
// ----------------------------------------------------------------------------
// jtlr_pkg
// Shared types and constants for the joint trajectory linear resampler.
// ----------------------------------------------------------------------------
package jtlr_pkg;

    localparam int JOINT_COUNT          = 6;
    localparam int MAX_SAMPLES_DEFAULT  = 63;
    localparam int TIME_W               = 32;
    localparam int POS_W                = 32;
    localparam int PERIOD_W             = 20;
    localparam int CFG_DATA_W           = 32;
    localparam int JIDX_W               = $clog2(JOINT_COUNT) > 0 ? $clog2(JOINT_COUNT) : 1;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd8000;

    typedef logic [0:0] t_cfg_index;
    localparam t_cfg_index REG_SAMPLE_PERIOD = 1'b0;
    localparam t_cfg_index REG_TRAJ_END      = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CHECK,
        ST_INTERP,
        ST_MD_WAIT,
        ST_EMIT,
        ST_ALIGN,
        ST_ALIGN_WAIT,
        ST_LAST
    } t_state;

endpackage

[rtl/joint_trajectory_linear_resampler.sv]
// ----------------------------------------------------------------------------
// joint_trajectory_linear_resampler
// Resamples six-joint waypoints onto a fixed time grid by linear
// interpolation between consecutive waypoints.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+--------------------------
//   in       | input     | i_in_valid / o_in_stall   | time, six joints, final
//   out      | output    | o_out_valid / i_out_stall | time, six joints, flags
//   cfg      | input     | i_cfg_we                  | index, data
//
// Each grid sample is interpolated joint by joint on the shared bit-serial
// multiply-divide unit, up to MAX_SAMPLES_PER_SEGMENT (default 63) samples
// per waypoint; a zero-length segment repeats the previous positions.
// The input stalls for the whole transaction; one result register decouples
// the output, so a stalled output only holds the next result load.
// Reset is synchronous, active low, and clears all control state.
// ----------------------------------------------------------------------------
module joint_trajectory_linear_resampler #(
    parameter int MAX_SAMPLES_PER_SEGMENT = jtlr_pkg::MAX_SAMPLES_DEFAULT
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [jtlr_pkg::TIME_W-1:0]            i_waypoint_time_us,
    input  logic signed [jtlr_pkg::POS_W-1:0]      i_joint_in_0,
    input  logic signed [jtlr_pkg::POS_W-1:0]      i_joint_in_1,
    input  logic signed [jtlr_pkg::POS_W-1:0]      i_joint_in_2,
    input  logic signed [jtlr_pkg::POS_W-1:0]      i_joint_in_3,
    input  logic signed [jtlr_pkg::POS_W-1:0]      i_joint_in_4,
    input  logic signed [jtlr_pkg::POS_W-1:0]      i_joint_in_5,
    input  logic                                   i_final_waypoint,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [jtlr_pkg::TIME_W-1:0]            o_sample_time_us,
    output logic signed [jtlr_pkg::POS_W-1:0]      o_joint_out_0,
    output logic signed [jtlr_pkg::POS_W-1:0]      o_joint_out_1,
    output logic signed [jtlr_pkg::POS_W-1:0]      o_joint_out_2,
    output logic signed [jtlr_pkg::POS_W-1:0]      o_joint_out_3,
    output logic signed [jtlr_pkg::POS_W-1:0]      o_joint_out_4,
    output logic signed [jtlr_pkg::POS_W-1:0]      o_joint_out_5,
    output logic                                   o_run_last,
    output logic                                   o_trajectory_done,
    output logic                                   o_overrun,
    input  logic                                   i_cfg_we,
    input  jtlr_pkg::t_cfg_index                   i_cfg_index,
    input  logic [jtlr_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int NJ     = jtlr_pkg::JOINT_COUNT;
    localparam int JW     = jtlr_pkg::JIDX_W;
    localparam int PW     = jtlr_pkg::PERIOD_W;
    localparam int K_W    = $clog2(MAX_SAMPLES_PER_SEGMENT + 1);
    localparam int SPAN_W = PW + K_W;

    jtlr_pkg::t_state r_state, n_state;

    // configuration
    logic [PW-1:0] r_period;
    logic [31:0]   r_end;

    // trajectory state
    logic        r_have;
    logic        r_pass;
    logic [31:0] r_prev_time;
    logic [31:0] r_prev_pos [NJ];
    logic [32:0] r_nst;

    // current waypoint and sample work
    logic [31:0]   r_t;
    logic [31:0]   r_cur [NJ];
    logic          r_final;
    logic          r_over;
    logic [31:0]   r_lim;
    logic [31:0]   r_den;
    logic [31:0]   r_num;
    logic [32:0]   r_s;
    logic [K_W-1:0] r_k;
    logic [JW-1:0] r_j;
    logic          r_neg;
    logic [31:0]   r_smp [NJ];

    // result register
    logic        r_out_valid;
    logic [31:0] r_out_time;
    logic [31:0] r_out_pos [NJ];
    logic        r_out_last;
    logic        r_out_done;
    logic        r_out_over;

    logic [31:0]       w_in_pos [NJ];
    logic [PW-1:0]     w_period;
    logic              w_accept;
    logic              w_out_free;
    logic              w_load_sample;
    logic              w_load_last;
    logic [SPAN_W-1:0] w_span;
    logic [33:0]       w_cap_end;
    logic [33:0]       w_s_next;
    logic              w_more;
    logic [32:0]       w_diff;
    logic [31:0]       w_mag;
    logic [31:0]       w_snum;
    logic [31:0]       w_end_m1;
    logic              w_last_j;
    logic              w_align;
    logic              w_round;
    logic [31:0]       w_qr;
    logic [31:0]       w_interp;

    logic        w_md_start;
    logic [31:0] w_md_x;
    logic [31:0] w_md_a;
    logic [31:0] w_md_d;
    logic        w_md_done;
    logic [31:0] w_md_quo;
    logic [31:0] w_md_rem;

    assign w_in_pos[0] = i_joint_in_0;
    assign w_in_pos[1] = i_joint_in_1;
    assign w_in_pos[2] = i_joint_in_2;
    assign w_in_pos[3] = i_joint_in_3;
    assign w_in_pos[4] = i_joint_in_4;
    assign w_in_pos[5] = i_joint_in_5;

    assign w_period   = (r_period == '0) ? PW'(1) : r_period;
    assign o_in_stall = (r_state != jtlr_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_span    = SPAN_W'(MAX_SAMPLES_PER_SEGMENT) * SPAN_W'(w_period);
    assign w_cap_end = {1'b0, r_s} + 34'(w_span);
    assign w_s_next  = {1'b0, r_s} + 34'(w_period);
    assign w_more    = (r_end != '0) && (r_s <= {1'b0, r_lim})
                       && (r_k < K_W'(MAX_SAMPLES_PER_SEGMENT));
    assign w_end_m1  = r_end - 32'd1;
    assign w_snum    = (r_s[31:0] > r_prev_time) ? r_s[31:0] - r_prev_time : '0;
    assign w_diff    = {r_cur[r_j][31], r_cur[r_j]} - {r_prev_pos[r_j][31], r_prev_pos[r_j]};
    assign w_mag     = w_diff[32] ? 32'(-w_diff) : w_diff[31:0];
    assign w_last_j  = (r_j == JW'(NJ - 1));
    assign w_align   = (r_nst <= {1'b0, r_t});

    // round to nearest, ties away from zero
    assign w_round  = ({1'b0, w_md_rem} << 1) >= {1'b0, r_den};
    assign w_qr     = w_md_quo + {31'd0, w_round};
    assign w_interp = r_neg ? r_prev_pos[r_j] - w_qr : r_prev_pos[r_j] + w_qr;

    assign w_load_sample = (r_state == jtlr_pkg::ST_EMIT) && w_out_free;
    assign w_load_last   = (r_state == jtlr_pkg::ST_LAST) && w_out_free;

    // shared unit operands
    always_comb begin
        w_md_start = 1'b0;
        w_md_x     = w_mag;
        w_md_a     = r_num;
        w_md_d     = r_den;
        unique case (r_state)
            jtlr_pkg::ST_INTERP: begin
                w_md_start = (r_den != '0);
            end
            jtlr_pkg::ST_ALIGN: begin
                w_md_start = w_align;
                w_md_x     = r_t - r_nst[31:0];
                w_md_a     = 32'd1;
                w_md_d     = 32'(w_period);
            end
            default: begin
                w_md_start = 1'b0;
            end
        endcase
    end

    jtlr_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_md_start),
        .i_x     (w_md_x),
        .i_a     (w_md_a),
        .i_d     (w_md_d),
        .o_done  (w_md_done),
        .o_quo   (w_md_quo),
        .o_rem   (w_md_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jtlr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            jtlr_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (!r_have) begin
                        if (i_final_waypoint || (r_end <= i_waypoint_time_us)) begin
                            n_state = jtlr_pkg::ST_LAST;
                        end
                    end else if (r_pass) begin
                        n_state = jtlr_pkg::ST_LAST;
                    end else begin
                        n_state = jtlr_pkg::ST_SETUP;
                    end
                end
            end
            jtlr_pkg::ST_SETUP: begin
                n_state = jtlr_pkg::ST_CHECK;
            end
            jtlr_pkg::ST_CHECK: begin
                n_state = w_more ? jtlr_pkg::ST_INTERP : jtlr_pkg::ST_ALIGN;
            end
            jtlr_pkg::ST_INTERP: begin
                if (r_den != '0) begin
                    n_state = jtlr_pkg::ST_MD_WAIT;
                end else if (w_last_j) begin
                    n_state = jtlr_pkg::ST_EMIT;
                end
            end
            jtlr_pkg::ST_MD_WAIT: begin
                if (w_md_done) begin
                    n_state = w_last_j ? jtlr_pkg::ST_EMIT : jtlr_pkg::ST_INTERP;
                end
            end
            jtlr_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_state = jtlr_pkg::ST_CHECK;
                end
            end
            jtlr_pkg::ST_ALIGN: begin
                if (w_align) begin
                    n_state = jtlr_pkg::ST_ALIGN_WAIT;
                end else begin
                    n_state = r_final ? jtlr_pkg::ST_LAST : jtlr_pkg::ST_IDLE;
                end
            end
            jtlr_pkg::ST_ALIGN_WAIT: begin
                if (w_md_done) begin
                    n_state = r_final ? jtlr_pkg::ST_LAST : jtlr_pkg::ST_IDLE;
                end
            end
            jtlr_pkg::ST_LAST: begin
                if (w_out_free) begin
                    n_state = jtlr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = jtlr_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= jtlr_pkg::PERIOD_RESET;
            r_end       <= '0;
            r_have      <= 1'b0;
            r_pass      <= 1'b0;
            r_prev_time <= '0;
            r_nst       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    jtlr_pkg::REG_SAMPLE_PERIOD: r_period <= i_cfg_data[PW-1:0];
                    jtlr_pkg::REG_TRAJ_END:      r_end    <= i_cfg_data[31:0];
                    default:                     r_end    <= r_end;
                endcase
            end

            if (w_accept && (!r_have || r_pass)) begin
                r_prev_time <= i_waypoint_time_us;
                if (!r_have) begin
                    r_have <= 1'b1;
                    r_nst  <= {1'b0, i_waypoint_time_us};
                    r_pass <= (r_end <= i_waypoint_time_us);
                end
            end

            if (r_state == jtlr_pkg::ST_ALIGN) begin
                r_prev_time <= r_t;
            end
            // jump to the first grid point past this waypoint
            if ((r_state == jtlr_pkg::ST_ALIGN_WAIT) && w_md_done) begin
                r_nst <= {1'b0, r_t} - {1'b0, w_md_rem} + 33'(w_period);
            end

            if (w_load_last && r_final) begin
                r_have <= 1'b0;
                r_pass <= 1'b0;
            end

            if (w_load_sample || w_load_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_t     <= i_waypoint_time_us;
            r_cur   <= w_in_pos;
            r_final <= i_final_waypoint;
            r_over  <= 1'b0;
            if (!r_have || r_pass) begin
                r_prev_pos <= w_in_pos;
            end
        end

        if (r_state == jtlr_pkg::ST_SETUP) begin
            r_lim <= (w_end_m1 < r_t) ? w_end_m1 : r_t;
            r_den <= (r_t > r_prev_time) ? r_t - r_prev_time : '0;
            r_s   <= r_nst;
            r_k   <= '0;
        end

        if (r_state == jtlr_pkg::ST_CHECK) begin
            if (r_k == '0) begin
                r_over <= (r_end != '0) && (w_cap_end <= {2'b00, r_lim});
            end
            r_num <= (w_snum > r_den) ? r_den : w_snum;
            r_j   <= '0;
        end

        if (r_state == jtlr_pkg::ST_INTERP) begin
            r_neg <= w_diff[32];
            if (r_den == '0) begin
                r_smp[r_j] <= r_prev_pos[r_j];
                r_j        <= r_j + JW'(1);
            end
        end

        if ((r_state == jtlr_pkg::ST_MD_WAIT) && w_md_done) begin
            r_smp[r_j] <= w_interp;
            r_j        <= r_j + JW'(1);
        end

        if (w_load_sample) begin
            r_out_time <= r_s[31:0];
            r_out_pos  <= r_smp;
            r_out_last <= !r_final && ((w_s_next > {2'b00, r_lim})
                          || (r_k == K_W'(MAX_SAMPLES_PER_SEGMENT - 1)));
            r_out_done <= 1'b0;
            r_out_over <= r_over;
            r_s        <= w_s_next[32:0];
            r_k        <= r_k + K_W'(1);
        end

        if (r_state == jtlr_pkg::ST_ALIGN) begin
            r_prev_pos <= r_cur;
        end

        if (w_load_last) begin
            r_out_time <= r_t;
            r_out_pos  <= r_cur;
            r_out_last <= 1'b1;
            r_out_done <= r_final;
            r_out_over <= r_over;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_sample_time_us  = r_out_time;
    assign o_joint_out_0     = r_out_pos[0];
    assign o_joint_out_1     = r_out_pos[1];
    assign o_joint_out_2     = r_out_pos[2];
    assign o_joint_out_3     = r_out_pos[3];
    assign o_joint_out_4     = r_out_pos[4];
    assign o_joint_out_5     = r_out_pos[5];
    assign o_run_last        = r_out_last;
    assign o_trajectory_done = r_out_done;
    assign o_overrun         = r_out_over;

    a_pass_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pass |-> r_have)
        else $error("passthrough set without a start waypoint");
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_trajectory_done) |-> o_run_last)
        else $error("trajectory end not marked as last of run");
    a_k_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == jtlr_pkg::ST_EMIT) |-> (r_k < K_W'(MAX_SAMPLES_PER_SEGMENT)))
        else $error("sample count past the cap");
    a_md_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_md_done |-> ((r_state == jtlr_pkg::ST_MD_WAIT)
                       || (r_state == jtlr_pkg::ST_ALIGN_WAIT)))
        else $error("muldiv result arrived outside a wait state");

endmodule

[rtl/jtlr_muldiv.sv]
// ----------------------------------------------------------------------------
// jtlr_muldiv
// Bit-serial unit: quotient and remainder of x * a / d, one bit of x a cycle.
// Requires a <= d and d != 0.
// ----------------------------------------------------------------------------
module jtlr_muldiv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_x,
    input  logic [31:0] i_a,
    input  logic [31:0] i_d,
    output logic        o_done,
    output logic [31:0] o_quo,
    output logic [31:0] o_rem
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [33:0] r_acc;
    logic [31:0] r_quo;
    logic [31:0] r_x;
    logic [31:0] r_a;
    logic [31:0] r_d;

    logic [33:0] w_sum;
    logic [33:0] w_d1;
    logic [33:0] w_d2;
    logic [33:0] n_acc;
    logic [31:0] n_quo;

    assign w_sum = {r_acc[32:0], 1'b0} + (r_x[31] ? {2'b00, r_a} : 34'd0);
    assign w_d1  = {2'b00, r_d};
    assign w_d2  = {1'b0, r_d, 1'b0};

    // partial remainder stays below 3*d, so at most two subtractions
    always_comb begin
        if (w_sum >= w_d2) begin
            n_acc = w_sum - w_d2;
            n_quo = {r_quo[30:0], 1'b0} + 32'd2;
        end else if (w_sum >= w_d1) begin
            n_acc = w_sum - w_d1;
            n_quo = {r_quo[30:0], 1'b0} + 32'd1;
        end else begin
            n_acc = w_sum;
            n_quo = {r_quo[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_quo <= '0;
            r_x   <= i_x;
            r_a   <= i_a;
            r_d   <= i_d;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_quo <= n_quo;
            r_x   <= {r_x[30:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_acc[31:0];

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("muldiv started while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_busy))
        else $error("muldiv done without work");
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_acc < {2'b00, r_d}))
        else $error("muldiv remainder not reduced");

endmodule
